>>> rtl/ilc_pkg.sv
`timescale 1ns / 1ps

package ilc_pkg;

    // Program length; positions count modulo this value.
    localparam int unsigned MAX_PROGRAM = 65536;
    localparam int unsigned POS_W       = (MAX_PROGRAM > 2) ? $clog2(MAX_PROGRAM) : 1;
    localparam int unsigned START_W     = 16;
    localparam int unsigned CNT_W       = 17;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_PROGRAM - 1);

    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
    localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic signed [CNT_W-1:0] CNT_NEG_ONE = {CNT_W{1'b1}};

    // Command characters
    localparam logic [7:0] SYM_OPEN   = 8'h5B;  // [
    localparam logic [7:0] SYM_CLOSE  = 8'h5D;  // ]
    localparam logic [7:0] SYM_RIGHT  = 8'h3E;  // >
    localparam logic [7:0] SYM_LEFT   = 8'h3C;  // <
    localparam logic [7:0] SYM_INC    = 8'h2B;  // +
    localparam logic [7:0] SYM_DEC    = 8'h2D;  // -
    localparam logic [7:0] SYM_OUTPUT = 8'h2E;  // .
    localparam logic [7:0] SYM_INPUT  = 8'h2C;  // ,

    typedef enum logic [2:0] {
        KIND_SIMPLE_STILL = 3'd0,
        KIND_SIMPLE_SHIFT = 3'd1,
        KIND_SCAN         = 3'd2,
        KIND_OTHER        = 3'd3,
        KIND_IO           = 3'd4
    } kind_t;

    typedef struct packed {
        logic [START_W-1:0] loop_start;
        kind_t              loop_kind;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] symbol;
        logic       first;
    } item_t;

    // Low bits of the position, zero-extended when the position is narrow.
    function automatic logic [START_W-1:0] to_start(input logic [POS_W-1:0] pos);
        logic [POS_W+START_W-1:0] ext;
        begin
            ext = (POS_W+START_W)'(pos);
            return ext[START_W-1:0];
        end
    endfunction

    function automatic logic signed [CNT_W-1:0] sat_step(
        input logic signed [CNT_W-1:0] v,
        input logic                    down
    );
        logic signed [CNT_W-1:0] r;
        begin
            if (down)
                r = (v == CNT_MIN) ? v : v - CNT_ONE;
            else
                r = (v == CNT_MAX) ? v : v + CNT_ONE;
            return r;
        end
    endfunction

endpackage

>>> rtl/ilc_in_stage.sv
`timescale 1ns / 1ps

module ilc_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            symbol_valid,
    output logic            symbol_stall,
    input  logic [7:0]      symbol,
    input  logic            first,
    input  logic            advance,
    output ilc_pkg::item_t  item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] symbol_reg;
    logic       first_reg;
    logic       accept;

    assign symbol_stall = valid_reg && !advance;
    assign accept       = symbol_valid && !symbol_stall;
    assign valid_next   = accept || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            symbol_reg <= symbol;
            first_reg  <= first;
        end
    end

    assign item.valid  = valid_reg;
    assign item.symbol = symbol_reg;
    assign item.first  = first_reg;

endmodule

>>> rtl/ilc_tracker.sv
`timescale 1ns / 1ps

module ilc_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  ilc_pkg::item_t    item,
    input  logic              advance,
    output logic              emit,
    output ilc_pkg::result_t  result
);

    logic [ilc_pkg::POS_W-1:0]         position_reg, position_next, here;
    logic                              in_loop_reg, in_loop_next, in_loop_cur;
    logic                              no_io_reg, no_io_next, no_io_cur;
    logic                              no_move_reg, no_move_next, no_move_cur;
    logic                              moves_only_reg, moves_only_next, moves_only_cur;
    logic [ilc_pkg::POS_W-1:0]         open_pos_reg, open_pos_next, open_pos_cur;
    logic signed [ilc_pkg::CNT_W-1:0]  net_shift_reg, net_shift_next, net_shift_cur;
    logic signed [ilc_pkg::CNT_W-1:0]  cell_change_reg, cell_change_next, cell_change_cur;
    ilc_pkg::kind_t                    kind;

    // A first byte sees the reset state.
    always_comb
    begin
        if (item.first)
        begin
            here            = '0;
            in_loop_cur     = 1'b0;
            no_io_cur       = 1'b0;
            no_move_cur     = 1'b1;
            moves_only_cur  = 1'b1;
            open_pos_cur    = '0;
            net_shift_cur   = '0;
            cell_change_cur = '0;
        end
        else
        begin
            here            = position_reg;
            in_loop_cur     = in_loop_reg;
            no_io_cur       = no_io_reg;
            no_move_cur     = no_move_reg;
            moves_only_cur  = moves_only_reg;
            open_pos_cur    = open_pos_reg;
            net_shift_cur   = net_shift_reg;
            cell_change_cur = cell_change_reg;
        end
    end

    always_comb
    begin
        if (no_io_cur && (net_shift_cur == '0)
            && (cell_change_cur == ilc_pkg::CNT_ONE || cell_change_cur == ilc_pkg::CNT_NEG_ONE))
            kind = no_move_cur ? ilc_pkg::KIND_SIMPLE_STILL : ilc_pkg::KIND_SIMPLE_SHIFT;
        else if (!no_io_cur)
            kind = ilc_pkg::KIND_IO;
        else
            kind = moves_only_cur ? ilc_pkg::KIND_SCAN : ilc_pkg::KIND_OTHER;
    end

    always_comb
    begin
        in_loop_next     = in_loop_cur;
        no_io_next       = no_io_cur;
        no_move_next     = no_move_cur;
        moves_only_next  = moves_only_cur;
        open_pos_next    = open_pos_cur;
        net_shift_next   = net_shift_cur;
        cell_change_next = cell_change_cur;
        emit             = 1'b0;

        unique case (item.symbol)
            ilc_pkg::SYM_OPEN:
            begin
                in_loop_next     = 1'b1;
                no_move_next     = 1'b1;
                moves_only_next  = 1'b1;
                no_io_next       = 1'b1;
                open_pos_next    = here;
                net_shift_next   = '0;
                cell_change_next = '0;
            end
            ilc_pkg::SYM_CLOSE:
            begin
                if (in_loop_cur)
                begin
                    emit             = 1'b1;
                    in_loop_next     = 1'b0;
                    net_shift_next   = '0;
                    cell_change_next = '0;
                end
            end
            ilc_pkg::SYM_RIGHT, ilc_pkg::SYM_LEFT:
            begin
                no_move_next   = 1'b0;
                net_shift_next = ilc_pkg::sat_step(net_shift_cur,
                                                   item.symbol == ilc_pkg::SYM_LEFT);
            end
            ilc_pkg::SYM_INC, ilc_pkg::SYM_DEC:
            begin
                moves_only_next = 1'b0;
                // Only changes made while back on the starting cell count.
                if (net_shift_cur == '0)
                    cell_change_next = ilc_pkg::sat_step(cell_change_cur,
                                                         item.symbol == ilc_pkg::SYM_DEC);
            end
            ilc_pkg::SYM_OUTPUT, ilc_pkg::SYM_INPUT:
            begin
                no_io_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        position_next = (here == ilc_pkg::POS_LAST) ? '0 : here + 1'b1;
    end

    assign result.loop_start = ilc_pkg::to_start(open_pos_cur);
    assign result.loop_kind  = kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            in_loop_reg     <= 1'b0;
            no_io_reg       <= 1'b0;
            no_move_reg     <= 1'b1;
            moves_only_reg  <= 1'b1;
            open_pos_reg    <= '0;
            net_shift_reg   <= '0;
            cell_change_reg <= '0;
        end
        else if (advance)
        begin
            position_reg    <= position_next;
            in_loop_reg     <= in_loop_next;
            no_io_reg       <= no_io_next;
            no_move_reg     <= no_move_next;
            moves_only_reg  <= moves_only_next;
            open_pos_reg    <= open_pos_next;
            net_shift_reg   <= net_shift_next;
            cell_change_reg <= cell_change_next;
        end
    end

endmodule

>>> rtl/ilc_out_stage.sv
`timescale 1ns / 1ps

module ilc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ilc_pkg::result_t  result,
    output logic              full,
    output logic              loop_valid,
    input  logic              loop_stall,
    output logic [15:0]       loop_start,
    output logic [2:0]        loop_kind
);

    logic             valid_reg;
    logic             valid_next;
    ilc_pkg::result_t result_reg;

    // Hold while stalled; a load only happens when the register can take it.
    assign valid_next = load || (valid_reg && loop_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign full       = valid_reg && loop_stall;
    assign loop_valid = valid_reg;
    assign loop_start = result_reg.loop_start;
    assign loop_kind  = 3'(result_reg.loop_kind);

endmodule

>>> rtl/bf_innermost_loop_classifier_core.sv
`timescale 1ns / 1ps

// Innermost-loop classifier. Program bytes enter on the symbol channel, one
// transfer per byte, with first marking the byte at position 0 of a new
// program. Each closing bracket that ends an open loop yields one transfer
// on the loop channel: the position of its opening bracket and the loop
// kind (simple without shift, simple with shift, scan, other, io); all
// other bytes yield nothing. The block takes one byte per cycle while the
// input is not stalled: a byte is registered on entry, and when it advances
// it updates the loop state and loads any result into the output register,
// which holds it until the loop channel takes it. The input stalls only when
// a byte that closes a loop meets a full, stalled output register.

module bf_innermost_loop_classifier_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        symbol_valid,
    output logic        symbol_stall,
    input  logic [7:0]  symbol,
    input  logic        first,
    output logic        loop_valid,
    input  logic        loop_stall,
    output logic [15:0] loop_start,
    output logic [2:0]  loop_kind
);

    ilc_pkg::item_t   item;
    ilc_pkg::result_t result;
    logic             emit;
    logic             out_full;
    logic             advance;

    // Drop a byte into the tracker unless its result has nowhere to go.
    assign advance = item.valid && !(emit && out_full);

    ilc_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall),
        .symbol       (symbol),
        .first        (first),
        .advance      (advance),
        .item         (item)
    );

    ilc_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .emit    (emit),
        .result  (result)
    );

    ilc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && emit),
        .result     (result),
        .full       (out_full),
        .loop_valid (loop_valid),
        .loop_stall (loop_stall),
        .loop_start (loop_start),
        .loop_kind  (loop_kind)
    );

endmodule
